/* sv/dlpw_pkg.sv */
package dlpw_pkg;

  // The step number reported with each result is always this wide.
  localparam int STEP_INDEX_BITS = 16;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_reg_t;

endpackage

/* sv/dlpw_if.sv */
interface dlpw_in_if import dlpw_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dlpw_out_if import dlpw_pkg::*; #(
  parameter int COORD_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                        moved;
  logic                        at_end;
  logic [STEP_INDEX_BITS-1:0]  step_index;

  modport source (output valid, output point_x, output point_y, output moved,
                  output at_end, output step_index, input ready);
  modport sink   (input valid, input point_x, input point_y, input moved,
                  input at_end, input step_index, output ready);
endinterface

/* sv/dda_line_point_walker_top.sv */
// Line point walker: steps through the grid points of a line between two
// endpoints held in configuration registers.
// Configuration: cfg_we writes cfg_data into the register selected by
// cfg_index (start x, start y, end x, end y). Any write rewinds the walk to
// step 0. Writes are expected only while no request is in flight.
// Input channel in_ch: each request carries restart. A restart returns the
// walk to step 0; otherwise the walk advances one step unless it is already
// at the end point.
// Output channel out_ch: exactly one result per request, holding the point
// at the current step, whether this request moved the walk, whether the walk
// is at the end, and the step number (low 16 bits).
// The result is registered and is valid in the cycle after the request
// is accepted. Throughput is one request per cycle while results are
// taken; the remainder accumulators update in a single add and compare
// per axis, which sets the per-request cost.
// When the receiver stalls, the result stays in the output register and
// in_ch.ready drops until it is taken; a new request is accepted in the same
// cycle that the pending result leaves.
// Reset clears all endpoints to zero and the walk to step 0.
module dda_line_point_walker_top import dlpw_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  dlpw_in_if.sink                   in_ch,
  dlpw_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data
);

  localparam int CB = COORD_BITS;
  // Running base point s + dir*q needs two extra bits of headroom.
  localparam int BW = COORD_BITS + 2;
  localparam logic signed [BW-1:0] ONE_B = BW'(1);

  // Configuration and derived per-axis values.
  logic signed [CB-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [CB-1:0]        dx_r, dy_r;
  logic                 negx_r, negy_r;

  // Walk state.
  logic [CB-1:0]        step_r, step_nxt;
  logic signed [BW-1:0] basex_r, basex_nxt, basey_r, basey_nxt;
  logic [CB-1:0]        remx_r, remx_nxt, remy_r, remy_nxt;

  // Output register.
  logic                        out_valid_r;
  logic signed [CB-1:0]        px_r, py_r;
  logic                        moved_r, at_end_r;
  logic [STEP_INDEX_BITS-1:0]  step_index_r;

  logic signed [CB-1:0] new_sx, new_sy, new_ex, new_ey;
  logic signed [CB:0]   diffx, diffy;
  logic [CB-1:0]        steps;
  logic                 accept, advance;
  logic [CB:0]          sumx, sumy;
  logic                 carryx, carryy;

  function automatic logic signed [CB-1:0] coord_f(input logic signed [BW-1:0] base,
                                                   input logic neg, input logic rem_nz);
    logic signed [BW-1:0] adj;
    adj = base;
    // A fractional part pulls the truncated value back toward zero.
    if (rem_nz) begin
      if (!neg && base[BW-1]) begin
        adj = base + ONE_B;
      end else if (neg && !base[BW-1] && (base != '0)) begin
        adj = base - ONE_B;
      end
    end
    return adj[CB-1:0];
  endfunction

  // Endpoints as they will stand after this cycle's configuration write.
  always_comb begin
    new_sx = sx_r;
    new_sy = sy_r;
    new_ex = ex_r;
    new_ey = ey_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_X: new_sx = $signed(cfg_data);
        REG_START_Y: new_sy = $signed(cfg_data);
        REG_END_X:   new_ex = $signed(cfg_data);
        REG_END_Y:   new_ey = $signed(cfg_data);
        default:     new_sx = sx_r;
      endcase
    end
    diffx = {new_ex[CB-1], new_ex} - {new_sx[CB-1], new_sx};
    diffy = {new_ey[CB-1], new_ey} - {new_sy[CB-1], new_sy};
  end

  assign steps = (dx_r > dy_r) ? dx_r : dy_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign advance     = accept && !in_ch.restart && (step_r < steps);

  assign sumx   = {1'b0, remx_r} + {1'b0, dx_r};
  assign sumy   = {1'b0, remy_r} + {1'b0, dy_r};
  assign carryx = (sumx >= {1'b0, steps});
  assign carryy = (sumy >= {1'b0, steps});

  always_comb begin
    step_nxt  = step_r;
    basex_nxt = basex_r;
    basey_nxt = basey_r;
    remx_nxt  = remx_r;
    remy_nxt  = remy_r;
    if (accept && in_ch.restart) begin
      step_nxt  = '0;
      basex_nxt = BW'(sx_r);
      basey_nxt = BW'(sy_r);
      remx_nxt  = '0;
      remy_nxt  = '0;
    end else if (advance) begin
      step_nxt = step_r + CB'(1);
      remx_nxt = carryx ? CB'(sumx - {1'b0, steps}) : sumx[CB-1:0];
      remy_nxt = carryy ? CB'(sumy - {1'b0, steps}) : sumy[CB-1:0];
      if (carryx) begin
        basex_nxt = negx_r ? basex_r - ONE_B : basex_r + ONE_B;
      end
      if (carryy) begin
        basey_nxt = negy_r ? basey_r - ONE_B : basey_r + ONE_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r        <= '0;
      sy_r        <= '0;
      ex_r        <= '0;
      ey_r        <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      negx_r      <= 1'b1;
      negy_r      <= 1'b1;
      step_r      <= '0;
      basex_r     <= '0;
      basey_r     <= '0;
      remx_r      <= '0;
      remy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sx_r    <= new_sx;
        sy_r    <= new_sy;
        ex_r    <= new_ex;
        ey_r    <= new_ey;
        dx_r    <= diffx[CB] ? CB'(-diffx) : diffx[CB-1:0];
        dy_r    <= diffy[CB] ? CB'(-diffy) : diffy[CB-1:0];
        // The direction is negative unless the start lies strictly below the end.
        negx_r  <= diffx[CB] || (diffx == '0);
        negy_r  <= diffy[CB] || (diffy == '0);
        step_r  <= '0;
        basex_r <= BW'(new_sx);
        basey_r <= BW'(new_sy);
        remx_r  <= '0;
        remy_r  <= '0;
      end else begin
        step_r  <= step_nxt;
        basex_r <= basex_nxt;
        basey_r <= basey_nxt;
        remx_r  <= remx_nxt;
        remy_r  <= remy_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r         <= coord_f(basex_nxt, negx_r, remx_nxt != '0);
      py_r         <= coord_f(basey_nxt, negy_r, remy_nxt != '0);
      moved_r      <= advance;
      at_end_r     <= (step_nxt == steps);
      step_index_r <= STEP_INDEX_BITS'(step_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.point_x    = px_r;
  assign out_ch.point_y    = py_r;
  assign out_ch.moved      = moved_r;
  assign out_ch.at_end     = at_end_r;
  assign out_ch.step_index = step_index_r;

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= steps)
    else $error("walk step beyond the line's step count");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ((remx_r == '0) || (remx_r < steps)) && ((remy_r == '0) || (remy_r < steps)))
    else $error("remainder accumulator not below the step count");

  a_advance_steps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_we |=> (step_r == $past(step_r) + CB'(1)))
    else $error("advance did not move the walk by one step");

  a_restart_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.restart |=> (step_r == '0) && (remx_r == '0) && (remy_r == '0))
    else $error("restart did not rewind the walk");

endmodule

/* bench/tb_dda_line_point_walker_top.sv */
module tb_dda_line_point_walker_top;
  import dlpw_pkg::*;

  localparam int CW = 16;
  localparam int SEGMENTS = 11;
  localparam int SEGMENT_REQS = 50;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic signed [CW-1:0]       px;
    logic signed [CW-1:0]       py;
    logic                       moved;
    logic                       at_end;
    logic [STEP_INDEX_BITS-1:0] step;
  } point_res_t;

  typedef enum {ROW_WRITE, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    cfg_reg_t      reg_sel;
    logic [CW-1:0] wdata;
    logic          restart;
    bit            typed;
    point_res_t    res;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CW-1:0]             cfg_data;

  dlpw_in_if                      in_if ();
  dlpw_out_if #(.COORD_BITS(CW))  out_if ();

  dda_line_point_walker_top #(.COORD_BITS(CW)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int         send_idle_pct = 15;
  int         recv_idle_pct = 60;
  logic       hold_go = 1'b0;
  logic       req_typed = 1'b0;
  point_res_t req_typed_res;

  // Line endpoints and walk position as the design should hold them.
  logic signed [CW-1:0] ln_sx = '0, ln_sy = '0, ln_ex = '0, ln_ey = '0;
  int walk_step = 0, xq = 0, xr = 0, yq = 0, yr = 0;

  point_res_t walk_exp_q[$];
  stim_row_t  stim_table[$];
  int         mismatches = 0;
  int         results_seen = 0;

  function automatic int span(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic void rewind_walk();
    walk_step = 0;
    xq = 0;
    xr = 0;
    yq = 0;
    yr = 0;
  endfunction

  function automatic void step_axis(int d, int n, ref int q, ref int r);
    r += d;
    if (r >= n) begin
      r -= n;
      q++;
    end
  endfunction

  // Exact start + dir*(q + r/n), truncated toward zero.
  function automatic logic signed [CW-1:0] axis_coord(logic signed [CW-1:0] s,
                                                      logic signed [CW-1:0] e,
                                                      int q, int r);
    int base;
    base = (s < e) ? int'(s) + q : int'(s) - q;
    if (r != 0) begin
      if (s < e && base < 0) base++;
      else if (!(s < e) && base > 0) base--;
    end
    return base[CW-1:0];
  endfunction

  function automatic point_res_t walk_predict(logic rs);
    int dx, dy, n;
    point_res_t r;
    dx = span(ln_sx, ln_ex);
    dy = span(ln_sy, ln_ey);
    n = (dx > dy) ? dx : dy;
    r.moved = 1'b0;
    if (rs) begin
      rewind_walk();
    end else if (walk_step < n) begin
      walk_step++;
      step_axis(dx, n, xq, xr);
      step_axis(dy, n, yq, yr);
      r.moved = 1'b1;
    end
    r.px = axis_coord(ln_sx, ln_ex, xq, xr);
    r.py = axis_coord(ln_sy, ln_ey, yq, yr);
    r.at_end = (walk_step == n);
    r.step = walk_step[STEP_INDEX_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch_bus
    point_res_t pr, got, e;
    if (!rst_n) begin
      ln_sx = '0;
      ln_sy = '0;
      ln_ex = '0;
      ln_ey = '0;
      rewind_walk();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_X: ln_sx = cfg_data;
          REG_START_Y: ln_sy = cfg_data;
          REG_END_X:   ln_ex = cfg_data;
          REG_END_Y:   ln_ey = cfg_data;
        endcase
        rewind_walk();
      end
      if (in_if.valid && in_if.ready) begin
        pr = walk_predict(in_if.restart);
        if (req_typed) pr = req_typed_res;
        walk_exp_q.push_back(pr);
      end
      if (out_if.valid && out_if.ready) begin
        got.px = out_if.point_x;
        got.py = out_if.point_y;
        got.moved = out_if.moved;
        got.at_end = out_if.at_end;
        got.step = out_if.step_index;
        if (walk_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no request outstanding", results_seen);
        end else begin
          e = walk_exp_q.pop_front();
          if (got.px !== e.px || got.py !== e.py || got.moved !== e.moved ||
              got.at_end !== e.at_end || got.step !== e.step) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected (%0d,%0d) moved=%0b end=%0b step=%0d, %s",
                       results_seen, e.px, e.py, e.moved, e.at_end, e.step,
                       $sformatf("got (%0d,%0d) moved=%0b end=%0b step=%0d",
                                 got.px, got.py, got.moved, got.at_end, got.step));
          end
        end
        results_seen++;
      end
    end
  end

  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_if.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void add_write(cfg_reg_t sel, int val);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.reg_sel = sel;
    row.wdata = val[CW-1:0];
    row.restart = 1'b0;
    row.typed = 1'b0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_req(logic rs);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.reg_sel = REG_START_X;
    row.wdata = '0;
    row.restart = rs;
    row.typed = 1'b0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_typed(logic rs, int x, int y, logic mv, logic ae, int st);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.reg_sel = REG_START_X;
    row.wdata = '0;
    row.restart = rs;
    row.typed = 1'b1;
    row.res.px = x[CW-1:0];
    row.res.py = y[CW-1:0];
    row.res.moved = mv;
    row.res.at_end = ae;
    row.res.step = st[STEP_INDEX_BITS-1:0];
    stim_table.push_back(row);
  endfunction

  function automatic logic signed [CW-1:0] extreme_coord();
    case ($urandom_range(3))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] s);
    int t;
    t = int'(s) + int'($urandom_range(40)) - 20;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[CW-1:0];
  endfunction

  task automatic send_req(logic rs, bit typed, point_res_t tres);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= rs;
    req_typed <= typed;
    req_typed_res <= tres;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Register writes wait until every outstanding request has its result.
  task automatic write_reg(cfg_reg_t sel, logic [CW-1:0] val);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (walk_exp_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure();
    logic signed [CW-1:0] sx, sy, ex, ey;
    case ($urandom_range(9))
      0: begin
        // Rewriting a register with its present value must still rewind the walk.
        case ($urandom_range(3))
          0: write_reg(REG_START_X, ln_sx);
          1: write_reg(REG_START_Y, ln_sy);
          2: write_reg(REG_END_X, ln_ex);
          default: write_reg(REG_END_Y, ln_ey);
        endcase
        return;
      end
      1: begin
        sx = extreme_coord();
        sy = extreme_coord();
        ex = extreme_coord();
        ey = extreme_coord();
      end
      2: begin
        sx = CW'($urandom);
        sy = CW'($urandom);
        ex = CW'($urandom);
        ey = CW'($urandom);
      end
      3: begin
        sx = CW'($urandom);
        sy = CW'($urandom);
        ex = sx;
        ey = sy;
      end
      default: begin
        // Short lines so that walks regularly reach their end point.
        sx = CW'($urandom);
        sy = CW'($urandom);
        ex = near_coord(sx);
        ey = near_coord(sy);
      end
    endcase
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
  endtask

  initial begin : stimulus
    point_res_t blank_res;
    int waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_START_X;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.restart = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // After reset the line has zero length at the origin.
    add_typed(1'b0, 0, 0, 1'b0, 1'b1, 0);
    add_typed(1'b1, 0, 0, 1'b0, 1'b1, 0);
    // Longest possible line, corner to corner.
    add_write(REG_START_X, -32768);
    add_write(REG_START_Y, 32767);
    add_write(REG_END_X, 32767);
    add_write(REG_END_Y, -32768);
    add_typed(1'b0, -32767, 32766, 1'b1, 1'b0, 1);
    add_req(1'b0);
    add_typed(1'b1, -32768, 32767, 1'b0, 1'b0, 0);
    // x crosses zero with a fractional offset; the last advance is issued at the end.
    add_write(REG_START_X, -4);
    add_write(REG_START_Y, 3);
    add_write(REG_END_X, 1);
    add_write(REG_END_Y, -4);
    repeat (8) add_req(1'b0);
    add_req(1'b1);
    // Zero-length line at the extreme corner.
    add_write(REG_START_X, 32767);
    add_write(REG_START_Y, -32768);
    add_write(REG_END_X, 32767);
    add_write(REG_END_Y, -32768);
    add_typed(1'b0, 32767, -32768, 1'b0, 1'b1, 0);
    add_typed(1'b1, 32767, -32768, 1'b0, 1'b1, 0);
    // Longest line walked the other way.
    add_write(REG_END_X, -32768);
    add_write(REG_END_Y, 32767);
    add_typed(1'b0, 32766, -32767, 1'b1, 1'b0, 1);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE)
        write_reg(stim_table[i].reg_sel, stim_table[i].wdata);
      else
        send_req(stim_table[i].restart, stim_table[i].typed, stim_table[i].res);
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct <= 15;
          recv_idle_pct <= 60;
        end
        1: begin
          send_idle_pct <= 60;
          recv_idle_pct <= 15;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        reconfigure();
        if (p == 2 && seg == 0) begin
          // Stall the result side while requests keep coming, to back up the input.
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        repeat (SEGMENT_REQS) send_req($urandom_range(11) == 0, 1'b0, blank_res);
      end
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (walk_exp_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (mismatches == 0 && walk_exp_q.size() == 0) begin
      $display("dda_line_point_walker_top verification clean");
    end else begin
      $display("dda_line_point_walker_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dda_line_point_walker_top verification failed");
    $finish;
  end

endmodule
